[design/bsa_pkg.sv]
// Package for the bitmap slot allocator.
// Holds the field widths, register indexes, command and status codes and
// the transaction payload types. Depends on nothing.
package bsa_pkg;

	localparam int DEF_MAX_SLOTS     = 1024;
	localparam int DEF_MAP_WORD_BITS = 32;

	localparam int ADDR_W     = 32;
	localparam int STRIDE_W   = 17;
	localparam int CNT_W      = 11;
	localparam int IDX_OUT_W  = 10;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_STRIDE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 2'd2;

	localparam logic [ADDR_W-1:0]   RST_BASE_ADDRESS = '0;
	localparam logic [STRIDE_W-1:0] RST_SLOT_STRIDE  = 17'd16;
	localparam logic [CNT_W-1:0]    RST_SLOTS_IN_USE = 11'd1024;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_BAD_ADDR = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t              command;
		logic [ADDR_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [IDX_OUT_W-1:0] slot_index;
		logic [ADDR_W-1:0]    slot_address;
	} rsp_t;

endpackage

[design/bsa_stream_if.sv]
// Valid/ready stream interface for the bitmap slot allocator.
// The payload type is set per channel through parameter T.
interface bsa_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[design/bitmap_slot_allocator.sv]
// Next-fit bitmap slot allocator. One transaction in flight at a time.
// Allocate: scans map words from the last allocated slot; a wrapped search adds a second
//   pass from slot 0.
// Free: divides the offset by the stride, then splits the slot into word and bit on the
//   shared compare-subtract divider. A waiting result does not block acceptance.
// Async reset clears the map (per-word valid flags) and search start, and resets config to defaults.
module bitmap_slot_allocator #(
	parameter int MAX_SLOTS     = bsa_pkg::DEF_MAX_SLOTS,
	parameter int MAP_WORD_BITS = bsa_pkg::DEF_MAP_WORD_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_wdata,
	bsa_stream_if.sink                     req,
	bsa_stream_if.source                   rsp
);

	localparam int CNT_MAX    = (1 << bsa_pkg::CNT_W) - 1;
	localparam int USED_SLOTS = (MAX_SLOTS < CNT_MAX) ? MAX_SLOTS : CNT_MAX;
	localparam int IDX_W      = $clog2(USED_SLOTS);
	localparam int N_W        = IDX_W + 1;
	localparam int MAP_WORDS  = (USED_SLOTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int WA_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_W      = $clog2(MAP_WORD_BITS);
	localparam int BASE_W     = $clog2(USED_SLOTS + MAP_WORD_BITS) + 1;
	localparam int PROD_W     = N_W + bsa_pkg::STRIDE_W;
	localparam int DIV_W      = bsa_pkg::ADDR_W;
	localparam int DCNT_W     = $clog2(IDX_W + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_AMUL,
		S_AADD,
		S_FMUL,
		S_FCHK,
		S_DIV1,
		S_DIV2,
		S_FRD,
		S_FWR,
		S_RESP
	} state_t;

	state_t state_q;

	// configuration
	logic [bsa_pkg::ADDR_W-1:0]   base_q;
	logic [bsa_pkg::STRIDE_W-1:0] stride_q;
	logic [bsa_pkg::CNT_W-1:0]    slots_q;

	// bitmap store and its per-word valid flags
	logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic [MAP_WORDS-1:0]     word_vld_q;

	// search start (last allocated slot), kept with its word and bit
	logic [IDX_W-1:0]  nss_q;
	logic [WA_W-1:0]   nss_word_q;
	logic [BASE_W-1:0] nss_base_q;
	logic [BIT_W-1:0]  nss_bit_q;

	// scan read side
	logic              pass_q;
	logic [WA_W-1:0]   rd_word_q;
	logic [BASE_W-1:0] rd_base_q;
	logic [BIT_W-1:0]  rd_lo_q;

	// scan check side
	logic                     chk_vld_s1;
	logic [WA_W-1:0]          chk_word_s1;
	logic [BASE_W-1:0]        chk_base_s1;
	logic [BIT_W-1:0]         chk_lo_s1;
	logic [MAP_WORD_BITS-1:0] rd_data_s1;
	logic                     rd_wv_s1;

	// free path and shared divider
	logic [bsa_pkg::ADDR_W-1:0] addr_q;
	logic [bsa_pkg::ADDR_W-1:0] off_q;
	logic                       off_ge_q;
	logic [PROD_W-1:0]          prod_q;
	logic [DIV_W-1:0]           rem_q;
	logic [DIV_W-1:0]           dsr_q;
	logic [IDX_W-1:0]           quo_q;
	logic [DCNT_W-1:0]          cnt_q;

	// result
	bsa_pkg::status_t           res_status_q;
	logic [IDX_W-1:0]           slot_q;
	logic [bsa_pkg::ADDR_W-1:0] res_addr_q;
	logic                       out_vld_q;
	bsa_pkg::rsp_t              out_q;

	logic [N_W-1:0]           n;
	logic                     words_left;
	logic                     issue;
	logic [WA_W-1:0]          rd_addr;
	logic                     rd_en;
	logic [MAP_WORD_BITS-1:0] eff_word;
	logic [BASE_W-1:0]        chk_lim;
	logic [MAP_WORD_BITS-1:0] free_bits;
	logic                     hit;
	logic [BIT_W-1:0]         hit_pos;
	logic                     alloc_hit;
	logic [BASE_W-1:0]        hit_slot;
	logic                     wr_en;
	logic [WA_W-1:0]          wr_addr;
	logic [MAP_WORD_BITS-1:0] wr_data;
	logic [N_W-1:0]           mul_a;
	logic [PROD_W-1:0]        mul_p;
	logic                     div_ge;
	logic [bsa_pkg::ADDR_W:0] off_full;
	logic                     out_load;

	assign n = (slots_q > bsa_pkg::CNT_W'(USED_SLOTS)) ? N_W'(USED_SLOTS) : N_W'(slots_q);

	assign words_left = rd_base_q < BASE_W'(n);
	assign eff_word   = rd_wv_s1 ? rd_data_s1 : '0;
	assign chk_lim    = BASE_W'(n) - chk_base_s1;

	always_comb begin
		for (int b = 0; b < MAP_WORD_BITS; b++) begin
			free_bits[b] = !eff_word[b] && (BASE_W'(b) < chk_lim) && (BIT_W'(b) >= chk_lo_s1);
		end
	end

	// lowest clear bit of the word under check
	always_comb begin
		hit_pos = '0;
		for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				hit_pos = BIT_W'(b);
			end
		end
	end

	assign hit       = |free_bits;
	assign alloc_hit = (state_q == S_SCAN) && chk_vld_s1 && hit;
	assign hit_slot  = chk_base_s1 + BASE_W'(hit_pos);
	assign issue     = (state_q == S_SCAN) && words_left && !alloc_hit;

	assign rd_addr = (state_q == S_FRD) ? quo_q[WA_W-1:0] : rd_word_q;
	assign rd_en   = issue || (state_q == S_FRD);

	assign wr_en   = alloc_hit || (state_q == S_FWR);
	assign wr_addr = alloc_hit ? chk_word_s1 : quo_q[WA_W-1:0];
	assign wr_data = alloc_hit ? (eff_word | (MAP_WORD_BITS'(1) << hit_pos))
	                           : (eff_word & ~(MAP_WORD_BITS'(1) << rem_q[BIT_W-1:0]));

	assign mul_a = (state_q == S_AMUL) ? N_W'(slot_q) : n;
	assign mul_p = {{bsa_pkg::STRIDE_W{1'b0}}, mul_a} * {{N_W{1'b0}}, stride_q};

	assign div_ge   = rem_q >= dsr_q;
	assign off_full = {1'b0, addr_q} - {1'b0, base_q};

	assign out_load = (state_q == S_RESP) && (!out_vld_q || rsp.ready);

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = out_vld_q;
	assign rsp.payload = out_q;

	// bitmap store: one read and one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= map_mem[rd_addr];
			rd_wv_s1   <= word_vld_q[rd_addr];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		chk_word_s1 <= rd_word_q;
		chk_base_s1 <= rd_base_q;
		chk_lo_s1   <= rd_lo_q;
		if (state_q == S_IDLE && req.valid) begin
			addr_q <= req.payload.free_address;
		end
		if (state_q == S_AMUL || state_q == S_FMUL) begin
			prod_q <= mul_p;
		end
		if (state_q == S_FMUL) begin
			off_q    <= off_full[bsa_pkg::ADDR_W-1:0];
			off_ge_q <= !off_full[bsa_pkg::ADDR_W];
		end
		if (out_load) begin
			out_q.status       <= res_status_q;
			out_q.slot_index   <= bsa_pkg::IDX_OUT_W'(slot_q);
			out_q.slot_address <= res_addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			base_q       <= bsa_pkg::RST_BASE_ADDRESS;
			stride_q     <= bsa_pkg::RST_SLOT_STRIDE;
			slots_q      <= bsa_pkg::RST_SLOTS_IN_USE;
			word_vld_q   <= '0;
			nss_q        <= '0;
			nss_word_q   <= '0;
			nss_base_q   <= '0;
			nss_bit_q    <= '0;
			pass_q       <= 1'b0;
			rd_word_q    <= '0;
			rd_base_q    <= '0;
			rd_lo_q      <= '0;
			chk_vld_s1   <= 1'b0;
			rem_q        <= '0;
			dsr_q        <= '0;
			quo_q        <= '0;
			cnt_q        <= '0;
			res_status_q <= bsa_pkg::ST_OK;
			slot_q       <= '0;
			res_addr_q   <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bsa_pkg::REG_BASE_ADDRESS: base_q   <= cfg_wdata;
					bsa_pkg::REG_SLOT_STRIDE:  stride_q <= cfg_wdata[bsa_pkg::STRIDE_W-1:0];
					bsa_pkg::REG_SLOTS_IN_USE: slots_q  <= cfg_wdata[bsa_pkg::CNT_W-1:0];
					default: ;
				endcase
			end

			if (wr_en) begin
				word_vld_q[wr_addr] <= 1'b1;
			end

			chk_vld_s1 <= issue;

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						if (req.payload.command == bsa_pkg::CMD_ALLOC) begin
							// start at the last allocated slot if it is still in the pool
							if (N_W'(nss_q) < n) begin
								rd_word_q <= nss_word_q;
								rd_base_q <= nss_base_q;
								rd_lo_q   <= nss_bit_q;
								pass_q    <= 1'b0;
							end else begin
								rd_word_q <= '0;
								rd_base_q <= '0;
								rd_lo_q   <= '0;
								pass_q    <= 1'b1;
							end
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FMUL;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						rd_word_q <= rd_word_q + WA_W'(1);
						rd_base_q <= rd_base_q + BASE_W'(MAP_WORD_BITS);
						rd_lo_q   <= '0;
					end
					if (alloc_hit) begin
						slot_q     <= IDX_W'(hit_slot);
						nss_q      <= IDX_W'(hit_slot);
						nss_word_q <= chk_word_s1;
						nss_base_q <= chk_base_s1;
						nss_bit_q  <= hit_pos;
						state_q    <= S_AMUL;
					end else if (!chk_vld_s1 && !words_left) begin
						if (pass_q) begin
							res_status_q <= bsa_pkg::ST_FULL;
							slot_q       <= '0;
							res_addr_q   <= '0;
							state_q      <= S_RESP;
						end else begin
							// wrap round to slot 0
							rd_word_q <= '0;
							rd_base_q <= '0;
							rd_lo_q   <= '0;
							pass_q    <= 1'b1;
						end
					end
				end
				S_AMUL: begin
					state_q <= S_AADD;
				end
				S_AADD: begin
					res_status_q <= bsa_pkg::ST_OK;
					res_addr_q   <= base_q + bsa_pkg::ADDR_W'(prod_q);
					state_q      <= S_RESP;
				end
				S_FMUL: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (off_ge_q && (off_q < bsa_pkg::ADDR_W'(prod_q))) begin
						rem_q   <= off_q;
						dsr_q   <= DIV_W'(stride_q) << (IDX_W - 1);
						quo_q   <= '0;
						cnt_q   <= DCNT_W'(IDX_W);
						state_q <= S_DIV1;
					end else begin
						res_status_q <= bsa_pkg::ST_BAD_ADDR;
						slot_q       <= '0;
						res_addr_q   <= '0;
						state_q      <= S_RESP;
					end
				end
				S_DIV1: begin
					if (cnt_q != '0) begin
						rem_q <= div_ge ? rem_q - dsr_q : rem_q;
						quo_q <= {quo_q[IDX_W-2:0], div_ge};
						dsr_q <= dsr_q >> 1;
						cnt_q <= cnt_q - DCNT_W'(1);
					end else begin
						// slot found; split it into word and bit on the same unit
						slot_q  <= quo_q;
						rem_q   <= DIV_W'(quo_q);
						dsr_q   <= DIV_W'(MAP_WORD_BITS) << (WA_W - 1);
						quo_q   <= '0;
						cnt_q   <= DCNT_W'(WA_W);
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (cnt_q != '0) begin
						rem_q <= div_ge ? rem_q - dsr_q : rem_q;
						quo_q <= {quo_q[IDX_W-2:0], div_ge};
						dsr_q <= dsr_q >> 1;
						cnt_q <= cnt_q - DCNT_W'(1);
					end else begin
						state_q <= S_FRD;
					end
				end
				S_FRD: begin
					state_q <= S_FWR;
				end
				S_FWR: begin
					res_status_q <= bsa_pkg::ST_OK;
					res_addr_q   <= '0;
					state_q      <= S_RESP;
				end
				S_RESP: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_err_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.payload.status != bsa_pkg::ST_OK)
		|-> (rsp.payload.slot_index == '0) && (rsp.payload.slot_address == '0))
		else $error("non-ok result carries a slot");

	a_word_marked: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> word_vld_q[$past(wr_addr)])
		else $error("written map word not flagged valid");

	a_hit_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_hit |-> (hit_slot < BASE_W'(n)))
		else $error("allocated slot outside pool");

	a_div_idle_io: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV1 || state_q == S_DIV2) |-> !wr_en && !rd_en)
		else $error("map access during divide");

endmodule
